// File: design/sktmt_pkg.sv
`default_nettype none
package sktmt_pkg;
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W = 27;
  localparam int GRADE_W = 16;
  localparam int ENTRY_W = KEY_W + 1 + GRADE_W;

  typedef enum logic [2:0] {
    F_INSERT = 3'd0,
    F_MOD_KEY = 3'd1,
    F_MOD_POS = 3'd2,
    F_DELETE = 3'd3,
    F_LOOK_KEY = 3'd4,
    F_LOOK_POS = 3'd5,
    F_MAX = 3'd6,
    F_NONE = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2,
    ST_NOGRADE = 2'd3
  } status_t;
endpackage
`default_nettype wire

// File: design/sorted_key_table_with_max_tracking_top.sv
// channel | signals                                       | dir
// in      | in_valid in_ready func key position has_grade grade | in
// out     | out_valid out_ready status out_key out_has_grade   | out
//         | out_grade out_position entry_count                 |
// one word at a time through a single memory read port and write port
// insert: entries compared and shifted from the top down, then rescan and read back
// delete: key search, then shift of the entries above it down, then rescan and output
// key search compares one entry at a time from position 0; a miss checks every entry
// rst clears count and maximum; table contents are undefined until written
// in_ready is low while a word is in work or a result waits
`default_nettype none
module sorted_key_table_with_max_tracking_top #(
  parameter int CAPACITY = sktmt_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] func,
  input  wire logic [26:0] key,
  input  wire logic [6:0] position,
  input  wire logic has_grade,
  input  wire logic [15:0] grade,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] status,
  output logic [26:0] out_key,
  output logic out_has_grade,
  output logic [15:0] out_grade,
  output logic [5:0] out_position,
  output logic [6:0] entry_count
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = sktmt_pkg::ENTRY_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FIND = 9'b000000010,
    S_FCMP = 9'b000000100,
    S_ISH  = 9'b000001000,
    S_DSH  = 9'b000010000,
    S_WR   = 9'b000100000,
    S_SCAN = 9'b001000000,
    S_RD   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic re, we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic [2:0] f;
  logic [26:0] k;
  logic hg;
  logic [15:0] g;
  logic [CW-1:0] fill;
  logic best_valid;
  logic [AW-1:0] best_position;
  logic [15:0] best_grade;
  logic [CW:0] ptr;
  logic [CW:0] rptr;
  logic pend;
  logic [AW-1:0] hit;
  logic [1:0] st;
  logic shown;
  logic [EW-1:0] held;
  logic ish_stop;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign entry_count = 7'(fill);

  // insert shift stop: read of entry ptr-1 compared with key
  assign ish_stop = k > rdata[EW-1 -: 27];

  always_comb begin
    re = 1'b0;
    raddr = ptr[AW-1:0];
    we = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = {k, hg, g};
    unique case (state)
      S_FIND, S_SCAN: begin
        re = ptr < (CW+1)'(fill);
      end
      S_ISH: begin
        raddr = AW'(ptr - 1'b1);
        re = !pend && ptr != 0;
        we = pend && !ish_stop;
        wdata = rdata;
      end
      S_DSH: begin
        raddr = AW'(ptr + 1'b1);
        re = !pend && (ptr + 1'b1) < (CW+1)'(fill);
        we = pend;
        wdata = rdata;
      end
      S_WR: we = 1'b1;
      S_RD: begin
        re = 1'b1;
        raddr = hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      fill <= '0;
      best_valid <= 1'b0;
      best_position <= '0;
      pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          f <= func; k <= key; hg <= has_grade; g <= grade;
          pend <= 1'b0; shown <= 1'b0;
          unique case (func) inside
            sktmt_pkg::F_INSERT: begin
              if (fill >= CW'(CAPACITY)) begin
                st <= sktmt_pkg::ST_FULL; state <= S_OUT;
              end else begin
                st <= sktmt_pkg::ST_OK; ptr <= (CW+1)'(fill); state <= S_ISH;
              end
            end
            sktmt_pkg::F_MOD_KEY, sktmt_pkg::F_DELETE, sktmt_pkg::F_LOOK_KEY: begin
              st <= sktmt_pkg::ST_OK; ptr <= '0; state <= S_FIND;
            end
            sktmt_pkg::F_MOD_POS, sktmt_pkg::F_LOOK_POS: begin
              if (position == 0 || position > 7'(fill)) begin
                st <= sktmt_pkg::ST_MISS; state <= S_OUT;
              end else begin
                st <= sktmt_pkg::ST_OK;
                hit <= AW'(position - 7'd1);
                state <= (func == sktmt_pkg::F_MOD_POS) ? S_WR : S_RD;
                ptr <= (CW+1)'(position - 7'd1);
              end
            end
            sktmt_pkg::F_MAX: begin
              if (!best_valid) begin
                st <= sktmt_pkg::ST_NOGRADE; state <= S_OUT;
              end else begin
                st <= sktmt_pkg::ST_OK; hit <= best_position; state <= S_RD;
              end
            end
            default: begin
              st <= sktmt_pkg::ST_MISS; state <= S_OUT;
            end
          endcase
        end
        S_FIND: begin
          if (ptr >= (CW+1)'(fill)) begin
            st <= sktmt_pkg::ST_MISS; state <= S_OUT;
          end else begin
            rptr <= ptr; state <= S_FCMP;
          end
        end
        S_FCMP: begin
          if (rdata[EW-1 -: 27] == k) begin
            hit <= AW'(rptr);
            if (f == sktmt_pkg::F_LOOK_KEY) state <= S_RD;
            else if (f == sktmt_pkg::F_MOD_KEY) begin
              ptr <= rptr; state <= S_WR;
            end else begin
              held <= rdata; shown <= 1'b1; ptr <= rptr; pend <= 1'b0;
              state <= S_DSH;
            end
          end else begin
            ptr <= rptr + 1'b1; state <= S_FIND;
          end
        end
        S_ISH: begin
          if (pend) begin
            pend <= 1'b0;
            if (ish_stop) state <= S_WR;
            else ptr <= ptr - 1'b1;
          end else if (ptr == 0) state <= S_WR;
          else pend <= 1'b1;
        end
        S_DSH: begin
          if (pend) begin
            pend <= 1'b0; ptr <= ptr + 1'b1;
          end else if ((ptr + 1'b1) < (CW+1)'(fill)) pend <= 1'b1;
          else begin
            fill <= fill - 1'b1; ptr <= '0; best_valid <= 1'b0; best_position <= '0;
            rptr <= '0; pend <= 1'b0; state <= S_SCAN;
          end
        end
        S_WR: begin
          hit <= AW'(ptr);
          if (f == sktmt_pkg::F_INSERT) fill <= fill + 1'b1;
          ptr <= '0; best_valid <= 1'b0; best_position <= '0; pend <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // pend marks a read in flight for entry rptr
          if (pend && rdata[16] &&
              (!best_valid || rdata[15:0] > best_grade)) begin
            best_valid <= 1'b1; best_position <= AW'(rptr); best_grade <= rdata[15:0];
          end
          if (ptr < (CW+1)'(fill)) begin
            pend <= 1'b1; rptr <= ptr; ptr <= ptr + 1'b1;
          end else begin
            pend <= 1'b0;
            state <= (f == sktmt_pkg::F_DELETE) ? S_OUT : S_RD;
          end
        end
        S_RD: begin
          if (pend) begin
            held <= rdata; shown <= 1'b1; state <= S_OUT; pend <= 1'b0;
          end else pend <= 1'b1;
        end
        S_OUT: begin
          status <= st;
          out_key <= shown ? held[EW-1 -: 27] : '0;
          out_has_grade <= shown ? held[16] : 1'b0;
          out_grade <= shown ? held[15:0] : '0;
          out_position <= shown ? 6'(hit) : '0;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready with result pending");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY)) else $error("fill over capacity");
  a_best: assert property (@(posedge clk) disable iff (rst)
    best_valid |-> (CW'(best_position) < fill)) else $error("maximum beyond fill");
`endif
endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [1:0] st;
    logic [26:0] k;
    logic hg;
    logic [15:0] g;
    logic [5:0] pos;
    logic [6:0] cnt;
  } table_result_t;

  class table_scoreboard;
    logic [26:0] keys[CAP];
    logic [15:0] grades[CAP];
    logic graded[CAP];
    int count;
    table_result_t pending[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void best(output bit found, output int bp);
      found = 0;
      bp = 0;
      for (int p = 0; p < count; p++)
        if (graded[p] && (!found || grades[p] > grades[bp])) begin
          found = 1;
          bp = p;
        end
    endfunction

    function int find(logic [26:0] k);
      for (int p = 0; p < count; p++)
        if (keys[p] == k) return p;
      return -1;
    endfunction

    function table_result_t show(sktmt_pkg::status_t s, int p);
      table_result_t r;
      r = '0;
      r.st = s;
      if (s == sktmt_pkg::ST_OK) begin
        r.k = keys[p];
        r.hg = graded[p];
        r.g = grades[p];
        r.pos = p[5:0];
      end
      r.cnt = count[6:0];
      return r;
    endfunction

    function void note_word(sktmt_pkg::func_t f, logic [26:0] k, logic [6:0] ps,
                            logic hg, logic [15:0] g);
      table_result_t r;
      int p;
      bit found;
      r = show(sktmt_pkg::ST_MISS, 0);
      case (f)
        sktmt_pkg::F_INSERT: begin
          if (count >= CAP) r = show(sktmt_pkg::ST_FULL, 0);
          else begin
            p = count;
            while (p > 0 && !(k > keys[p-1])) begin
              keys[p] = keys[p-1];
              grades[p] = grades[p-1];
              graded[p] = graded[p-1];
              p--;
            end
            keys[p] = k;
            grades[p] = g;
            graded[p] = hg;
            count++;
            r = show(sktmt_pkg::ST_OK, p);
          end
        end
        sktmt_pkg::F_MOD_KEY, sktmt_pkg::F_MOD_POS: begin
          if (f == sktmt_pkg::F_MOD_KEY) p = find(k);
          else p = (ps >= 1 && ps <= count) ? int'(ps) - 1 : -1;
          if (p >= 0) begin
            keys[p] = k;
            grades[p] = g;
            graded[p] = hg;
            r = show(sktmt_pkg::ST_OK, p);
          end
        end
        sktmt_pkg::F_DELETE: begin
          p = find(k);
          if (p >= 0) begin
            r = show(sktmt_pkg::ST_OK, p);
            for (int j = p; j + 1 < count; j++) begin
              keys[j] = keys[j+1];
              grades[j] = grades[j+1];
              graded[j] = graded[j+1];
            end
            count--;
            r.cnt = count[6:0];
          end
        end
        sktmt_pkg::F_LOOK_KEY: begin
          p = find(k);
          if (p >= 0) r = show(sktmt_pkg::ST_OK, p);
        end
        sktmt_pkg::F_LOOK_POS: begin
          if (ps >= 1 && ps <= count) r = show(sktmt_pkg::ST_OK, int'(ps) - 1);
        end
        sktmt_pkg::F_MAX: begin
          best(found, p);
          r = found ? show(sktmt_pkg::ST_OK, p) : show(sktmt_pkg::ST_NOGRADE, 0);
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_word(table_result_t a);
      table_result_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.st !== a.st) begin
        $display("%0t status exp %0d got %0d", $time, e.st, a.st);
        errors++;
      end
      if (e.k !== a.k) begin
        $display("%0t out_key exp %0d got %0d", $time, e.k, a.k);
        errors++;
      end
      if (e.hg !== a.hg) begin
        $display("%0t out_has_grade exp %0d got %0d", $time, e.hg, a.hg);
        errors++;
      end
      if (e.g !== a.g) begin
        $display("%0t out_grade exp %0d got %0d", $time, e.g, a.g);
        errors++;
      end
      if (e.pos !== a.pos) begin
        $display("%0t out_position exp %0d got %0d", $time, e.pos, a.pos);
        errors++;
      end
      if (e.cnt !== a.cnt) begin
        $display("%0t entry_count exp %0d got %0d", $time, e.cnt, a.cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] func = '0;
  logic [26:0] key = '0;
  logic [6:0] position = '0;
  logic has_grade = 0;
  logic [15:0] grade = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [26:0] out_key;
  logic out_has_grade;
  logic [15:0] out_grade;
  logic [5:0] out_position;
  logic [6:0] entry_count;

  table_scoreboard sb = new();
  int cycles = 0;
  bit hold_off = 0;
  logic [26:0] used_keys[$];

  sorted_key_table_with_max_tracking_top dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver with its own stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word({status, out_key, out_has_grade, out_grade, out_position, entry_count});
    if (rst || hold_off) out_ready <= 0;
    else if ((cycles / 300) % 3 == 0) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_word(sktmt_pkg::func_t f, logic [26:0] k, logic [6:0] ps, logic hg,
                           logic [15:0] g);
    in_valid <= 1;
    func <= f;
    key <= k;
    position <= ps;
    has_grade <= hg;
    grade <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(f, k, ps, hg, g);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 2) == 0 ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [26:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 27'd99999999 : 27'd0;
    return 27'($urandom_range(0, 99999999));
  endfunction

  initial begin
    logic [26:0] k;
    sktmt_pkg::func_t f;
    int burst;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send_word(sktmt_pkg::F_MAX, 27'd0, 7'd1, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_LOOK_POS, 27'd0, 7'd1, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_DELETE, 27'd5, 7'd0, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_INSERT, 27'd99999999, 7'd0, 1'b0, 16'hffff);
    send_word(sktmt_pkg::F_MAX, 27'd0, 7'd0, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_INSERT, 27'd0, 7'd0, 1'b1, 16'h0);
    send_word(sktmt_pkg::F_INSERT, 27'd0, 7'd0, 1'b1, 16'hffff);
    send_word(sktmt_pkg::F_INSERT, 27'd500, 7'd0, 1'b1, 16'hffff);
    send_word(sktmt_pkg::F_MAX, 27'd0, 7'd0, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_MOD_KEY, 27'd0, 7'd0, 1'b1, 16'h1234);
    send_word(sktmt_pkg::F_MOD_KEY, 27'd7, 7'd0, 1'b1, 16'h1);
    send_word(sktmt_pkg::F_MOD_POS, 27'd77, 7'd4, 1'b0, 16'h5555);
    send_word(sktmt_pkg::F_MOD_POS, 27'd1, 7'd0, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_MOD_POS, 27'd1, 7'd127, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_LOOK_KEY, 27'd500, 7'd0, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_LOOK_POS, 27'd0, 7'd5, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_LOOK_POS, 27'd0, 7'd64, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_NONE, 27'h7ffffff, 7'h7f, 1'b1, 16'hffff);
    send_word(sktmt_pkg::F_DELETE, 27'd500, 7'd0, 1'b0, 16'd0);
    send_word(sktmt_pkg::F_MAX, 27'd0, 7'd0, 1'b0, 16'd0);
    // fill past capacity; the receiver holds off at the start, which stalls the sender
    hold_off <= 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off <= 0;
      end
      for (int i = 0; i < 66; i++)
        send_word(sktmt_pkg::F_INSERT, 27'($urandom_range(0, 99999999)), 7'd0,
                  1'($urandom_range(0, 1)), 16'($urandom));
    join
    send_word(sktmt_pkg::F_MAX, 27'd0, 7'd0, 1'b0, 16'd0);
    // random
    for (int i = 0; i < 1500; i += burst) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3: f = sktmt_pkg::F_INSERT;
          4, 5: f = sktmt_pkg::F_DELETE;
          6: f = sktmt_pkg::F_MOD_KEY;
          7: f = sktmt_pkg::F_MOD_POS;
          8, 9: f = sktmt_pkg::F_LOOK_KEY;
          10, 11: f = sktmt_pkg::F_LOOK_POS;
          12, 13, 14: f = sktmt_pkg::F_MAX;
          default: f = sktmt_pkg::F_NONE;
        endcase
        if (sb.count > 50 && f == sktmt_pkg::F_INSERT && $urandom_range(0, 1))
          f = sktmt_pkg::F_DELETE;
        k = pick_key();
        if (f == sktmt_pkg::F_INSERT) used_keys.push_back(k);
        if (used_keys.size() > 200) void'(used_keys.pop_front());
        send_word(f, k,
                  $urandom_range(0, 3) == 0 ? 7'($urandom)
                                            : 7'($urandom_range(0, sb.count + 1)),
                  1'($urandom_range(0, 1)), 16'($urandom));
      end
      gap();
    end
    in_valid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// File: sorted_key_table_with_max_tracking_top.f
design/sktmt_pkg.sv
design/sorted_key_table_with_max_tracking_top.sv
tb/testbench.sv
